>>> sv/sc2a_pkg.sv
// sc2a_pkg: shared constants, hotkey codes and set-1 scan code tables
// for the scan code decoder; depends on nothing
package sc2a_pkg;

  // hotkey command codes
  typedef enum logic [2:0] {
    HK_NONE      = 3'd0,
    HK_EXIT      = 3'd1,
    HK_LOG_DOWN  = 3'd2,
    HK_LOG_UP    = 3'd3,
    HK_SEL_TERM  = 3'd4,
    HK_NEW_PROC  = 3'd5,
    HK_KILL_PROC = 3'd6
  } hotkey_cmd_t;

  // modifier and lock scan codes, press and release
  localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK   = 8'hB8;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_NUM         = 8'h45;
  localparam logic [7:0] SC_ESC_BREAK   = 8'h81;
  localparam logic [7:0] SC_LAST        = 8'h58;
  localparam logic [7:0] SC_PAD_FIRST   = 8'h47;
  localparam logic [7:0] SC_PAD_LAST    = 8'h53;
  localparam logic [7:0] SC_PAD_MINUS   = 8'h4A;
  localparam logic [7:0] SC_PAD_PLUS    = 8'h4E;

  // key code values that matter for hotkeys
  localparam logic [7:0] KC_ESC    = 8'd27;
  localparam logic [7:0] KC_MINUS  = 8'd45;
  localparam logic [7:0] KC_EQUALS = 8'd61;
  localparam logic [7:0] KC_N      = 8'd110;
  localparam logic [7:0] KC_Q      = 8'd113;
  localparam logic [7:0] KC_ZERO   = 8'd48;
  localparam logic [7:0] KC_NINE   = 8'd57;
  localparam logic [7:0] KC_LOW_A  = 8'h61;
  localparam logic [7:0] KC_LOW_Z  = 8'h7A;

  localparam logic [2:0] ESC_EXIT_RESET = 3'd3;
  localparam logic [2:0] ESC_CNT_MAX    = 3'd7;

  // unshifted key codes
  function automatic logic [7:0] plain_code(input logic [6:0] idx);
    unique case (idx)
      7'h01: plain_code = 8'h1B;  7'h02: plain_code = 8'h31;  7'h03: plain_code = 8'h32;
      7'h04: plain_code = 8'h33;  7'h05: plain_code = 8'h34;  7'h06: plain_code = 8'h35;
      7'h07: plain_code = 8'h36;  7'h08: plain_code = 8'h37;  7'h09: plain_code = 8'h38;
      7'h0A: plain_code = 8'h39;  7'h0B: plain_code = 8'h30;  7'h0C: plain_code = 8'h2D;
      7'h0D: plain_code = 8'h3D;  7'h0E: plain_code = 8'h08;  7'h0F: plain_code = 8'h09;
      7'h10: plain_code = 8'h71;  7'h11: plain_code = 8'h77;  7'h12: plain_code = 8'h65;
      7'h13: plain_code = 8'h72;  7'h14: plain_code = 8'h74;  7'h15: plain_code = 8'h79;
      7'h16: plain_code = 8'h75;  7'h17: plain_code = 8'h69;  7'h18: plain_code = 8'h6F;
      7'h19: plain_code = 8'h70;  7'h1A: plain_code = 8'h5B;  7'h1B: plain_code = 8'h5D;
      7'h1C: plain_code = 8'h0A;  7'h1E: plain_code = 8'h61;  7'h1F: plain_code = 8'h73;
      7'h20: plain_code = 8'h64;  7'h21: plain_code = 8'h66;  7'h22: plain_code = 8'h67;
      7'h23: plain_code = 8'h68;  7'h24: plain_code = 8'h6A;  7'h25: plain_code = 8'h6B;
      7'h26: plain_code = 8'h6C;  7'h27: plain_code = 8'h3B;  7'h28: plain_code = 8'h27;
      7'h29: plain_code = 8'h60;  7'h2B: plain_code = 8'h5C;  7'h2C: plain_code = 8'h7A;
      7'h2D: plain_code = 8'h78;  7'h2E: plain_code = 8'h63;  7'h2F: plain_code = 8'h76;
      7'h30: plain_code = 8'h62;  7'h31: plain_code = 8'h6E;  7'h32: plain_code = 8'h6D;
      7'h33: plain_code = 8'h2C;  7'h34: plain_code = 8'h2E;  7'h35: plain_code = 8'h2F;
      7'h37: plain_code = 8'h2A;  7'h39: plain_code = 8'h20;  7'h3B: plain_code = 8'h80;
      7'h3C: plain_code = 8'h81;  7'h3D: plain_code = 8'h82;  7'h3E: plain_code = 8'h83;
      7'h3F: plain_code = 8'h84;  7'h40: plain_code = 8'h85;  7'h41: plain_code = 8'h86;
      7'h42: plain_code = 8'h87;  7'h43: plain_code = 8'h88;  7'h44: plain_code = 8'h89;
      7'h47: plain_code = 8'h37;  7'h48: plain_code = 8'h38;  7'h49: plain_code = 8'h39;
      7'h4A: plain_code = 8'h2D;  7'h4B: plain_code = 8'h34;  7'h4C: plain_code = 8'h35;
      7'h4D: plain_code = 8'h36;  7'h4E: plain_code = 8'h2B;  7'h4F: plain_code = 8'h31;
      7'h50: plain_code = 8'h32;  7'h51: plain_code = 8'h33;  7'h52: plain_code = 8'h30;
      7'h53: plain_code = 8'h2E;  7'h57: plain_code = 8'h8A;  7'h58: plain_code = 8'h8B;
      default: plain_code = 8'h00;
    endcase
  endfunction

  // shifted key codes, numpad navigation codes
  function automatic logic [7:0] alt_code(input logic [6:0] idx);
    unique case (idx)
      7'h02: alt_code = 8'h21;  7'h03: alt_code = 8'h40;  7'h04: alt_code = 8'h23;
      7'h05: alt_code = 8'h24;  7'h06: alt_code = 8'h25;  7'h07: alt_code = 8'h5E;
      7'h08: alt_code = 8'h26;  7'h09: alt_code = 8'h2A;  7'h0A: alt_code = 8'h28;
      7'h0B: alt_code = 8'h29;  7'h0C: alt_code = 8'h5F;  7'h0D: alt_code = 8'h2B;
      7'h10: alt_code = 8'h51;  7'h11: alt_code = 8'h57;  7'h12: alt_code = 8'h45;
      7'h13: alt_code = 8'h52;  7'h14: alt_code = 8'h54;  7'h15: alt_code = 8'h59;
      7'h16: alt_code = 8'h55;  7'h17: alt_code = 8'h49;  7'h18: alt_code = 8'h4F;
      7'h19: alt_code = 8'h50;  7'h1A: alt_code = 8'h7B;  7'h1B: alt_code = 8'h7D;
      7'h1E: alt_code = 8'h41;  7'h1F: alt_code = 8'h53;  7'h20: alt_code = 8'h44;
      7'h21: alt_code = 8'h46;  7'h22: alt_code = 8'h47;  7'h23: alt_code = 8'h48;
      7'h24: alt_code = 8'h4A;  7'h25: alt_code = 8'h4B;  7'h26: alt_code = 8'h4C;
      7'h27: alt_code = 8'h3A;  7'h28: alt_code = 8'h22;  7'h29: alt_code = 8'h7E;
      7'h2B: alt_code = 8'h7C;  7'h2C: alt_code = 8'h5A;  7'h2D: alt_code = 8'h58;
      7'h2E: alt_code = 8'h43;  7'h2F: alt_code = 8'h56;  7'h30: alt_code = 8'h42;
      7'h31: alt_code = 8'h4E;  7'h32: alt_code = 8'h4D;  7'h33: alt_code = 8'h3C;
      7'h34: alt_code = 8'h3E;  7'h35: alt_code = 8'h3F;  7'h47: alt_code = 8'h8C;
      7'h48: alt_code = 8'h8E;  7'h49: alt_code = 8'h92;  7'h4B: alt_code = 8'h90;
      7'h4D: alt_code = 8'h91;  7'h4F: alt_code = 8'h8D;  7'h50: alt_code = 8'h8F;
      7'h51: alt_code = 8'h93;  7'h52: alt_code = 8'h94;  7'h53: alt_code = 8'h95;
      default: alt_code = 8'h00;
    endcase
  endfunction

endpackage

>>> sv/scan_code_to_ascii_decoder.sv
// scan_code_to_ascii_decoder: set-1 scan code to key code and hotkey decoder
// depends on sc2a_pkg for hotkey codes, scan code constants and tables
// an accepted scan byte passes through the input register, then the result register
// accepts one scan byte per cycle while the receiver does not stall the output
// lock, modifier and esc count flags update as each item moves into the result register
// reset (rst_n low, synchronous): both stages empty, all flags cleared, esc exit count 3
module scan_code_to_ascii_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_key_code,
  output logic [2:0] out_hotkey_command,
  output logic [3:0] out_terminal_index
);
  import sc2a_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  logic [7:0]  out_key_r;
  hotkey_cmd_t out_cmd_r;
  logic [3:0]  out_term_r;

  logic        caps_r, num_r, shl_r, shr_r, ctrl_r, alt_r;
  logic        caps_nxt, num_nxt, shl_nxt, shr_nxt, ctrl_nxt, alt_nxt;
  logic [2:0]  esc_cnt_r, esc_cnt_nxt, esc_inc;
  logic [2:0]  esc_exit_r;

  logic        out_free, s1_fire, in_fire;
  logic        is_mod, shift, is_pad;
  logic [7:0]  lo, hi, lookup;
  logic [7:0]  key_nxt;
  hotkey_cmd_t cmd_nxt;
  logic [3:0]  term_nxt;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // table lookup for non-modifier bytes
  always_comb begin
    shift  = shl_r || shr_r;
    lo     = plain_code(s1_byte_r[6:0]);
    hi     = alt_code(s1_byte_r[6:0]);
    is_pad = (s1_byte_r >= SC_PAD_FIRST) && (s1_byte_r <= SC_PAD_LAST) &&
             (s1_byte_r != SC_PAD_MINUS) && (s1_byte_r != SC_PAD_PLUS);
    if (s1_byte_r > SC_LAST) begin
      lookup = 8'h00;
    end else if (is_pad) begin
      lookup = num_r ? lo : hi;
    end else if (lo >= KC_LOW_A && lo <= KC_LOW_Z) begin
      lookup = (caps_r != shift) ? hi : lo;
    end else if (hi != 8'h00 && shift) begin
      lookup = hi;
    end else begin
      lookup = lo;
    end
  end

  // modifier and lock flag updates
  always_comb begin
    caps_nxt = caps_r;
    num_nxt  = num_r;
    shl_nxt  = shl_r;
    shr_nxt  = shr_r;
    ctrl_nxt = ctrl_r;
    alt_nxt  = alt_r;
    is_mod   = 1'b1;
    unique case (s1_byte_r)
      SC_CTRL_MAKE:   ctrl_nxt = 1'b1;
      SC_CTRL_BREAK:  ctrl_nxt = 1'b0;
      SC_LSHIFT_MAKE: shl_nxt  = 1'b1;
      SC_LSHIFT_BRK:  shl_nxt  = 1'b0;
      SC_RSHIFT_MAKE: shr_nxt  = 1'b1;
      SC_RSHIFT_BRK:  shr_nxt  = 1'b0;
      SC_ALT_MAKE:    alt_nxt  = 1'b1;
      SC_ALT_BREAK:   alt_nxt  = 1'b0;
      SC_CAPS:        caps_nxt = !caps_r;
      SC_NUM:         num_nxt  = !num_r;
      default:        is_mod   = 1'b0;
    endcase
  end

  // esc counting and hotkey selection
  always_comb begin
    key_nxt     = is_mod ? 8'h00 : lookup;
    cmd_nxt     = HK_NONE;
    term_nxt    = 4'd0;
    esc_inc     = (esc_cnt_r < ESC_CNT_MAX) ? esc_cnt_r + 3'd1 : esc_cnt_r;
    esc_cnt_nxt = esc_cnt_r;
    if (key_nxt == KC_ESC) begin
      esc_cnt_nxt = esc_inc;
      if (esc_inc == esc_exit_r) begin
        cmd_nxt     = HK_EXIT;
        esc_cnt_nxt = 3'd0;
      end
    end else if (s1_byte_r != SC_ESC_BREAK) begin
      esc_cnt_nxt = 3'd0;
    end
    if (cmd_nxt == HK_NONE) begin
      if (ctrl_r && key_nxt == KC_MINUS) begin
        cmd_nxt = HK_LOG_DOWN;
        key_nxt = 8'h00;
      end else if (ctrl_r && key_nxt == KC_EQUALS) begin
        cmd_nxt = HK_LOG_UP;
        key_nxt = 8'h00;
      end else if (alt_r && key_nxt >= KC_ZERO && key_nxt <= KC_NINE) begin
        cmd_nxt  = HK_SEL_TERM;
        term_nxt = 4'(key_nxt - KC_ZERO);
        key_nxt  = 8'h00;
      end else if (ctrl_r && key_nxt == KC_N) begin
        cmd_nxt = HK_NEW_PROC;
        key_nxt = 8'h00;
      end else if (ctrl_r && key_nxt == KC_Q) begin
        cmd_nxt = HK_KILL_PROC;
        key_nxt = 8'h00;
      end
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      caps_r      <= 1'b0;
      num_r       <= 1'b0;
      shl_r       <= 1'b0;
      shr_r       <= 1'b0;
      ctrl_r      <= 1'b0;
      alt_r       <= 1'b0;
      esc_cnt_r   <= 3'd0;
      esc_exit_r  <= ESC_EXIT_RESET;
    end else begin
      if (cfg_wr_en) begin
        esc_exit_r <= cfg_wr_data;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        caps_r      <= caps_nxt;
        num_r       <= num_nxt;
        shl_r       <= shl_nxt;
        shr_r       <= shr_nxt;
        ctrl_r      <= ctrl_nxt;
        alt_r       <= alt_nxt;
        esc_cnt_r   <= esc_cnt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_scan_byte;
    end
    if (s1_fire) begin
      out_key_r  <= key_nxt;
      out_cmd_r  <= cmd_nxt;
      out_term_r <= term_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_code       = out_key_r;
  assign out_hotkey_command = out_cmd_r;
  assign out_terminal_index = out_term_r;

  // terminal index is only nonzero with the select terminal command
  a_term_only_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cmd_r == HK_SEL_TERM || out_term_r == 4'd0))
    else $error("terminal index set without select terminal command");

  // hotkeys other than exit swallow the key
  a_hotkey_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r != HK_NONE && out_cmd_r != HK_EXIT |-> out_key_r == 8'h00)
    else $error("key code passed along with a hotkey");

  // exit restarts the esc count
  a_exit_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && cmd_nxt == HK_EXIT |=> esc_cnt_r == 3'd0)
    else $error("esc count not cleared on exit");

  // exit always comes with the esc key code
  a_exit_is_esc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && cmd_nxt == HK_EXIT |=> out_key_r == KC_ESC)
    else $error("exit command without esc key code");

  // stall only while the decode stage holds an item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with decode stage empty");

endmodule

>>> verif/scan_decode_checker.sv
`timescale 1ns / 100ps
// scan_decode_checker: watches the scan byte and key event channels of the decoder,
// predicts each key event from its own lock, modifier and esc state and compares
// depends on sc2a_pkg for hotkey codes and scan code constants
module scan_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_scan_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_key_code,
  input  logic [2:0] out_hotkey_command,
  input  logic [3:0] out_terminal_index,
  output int         fail_count,
  output int         pending
);
  import sc2a_pkg::*;

  typedef struct packed {
    logic [7:0]  key;
    hotkey_cmd_t cmd;
    logic [3:0]  term;
  } key_event_t;

  localparam int MAP_LAST = 88;

  // unshifted key per scan code 0x00..0x58, code 0x00 in the top byte
  localparam logic [8*(MAP_LAST+1)-1:0] PLAIN_KEYS = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
    8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h8A,
    8'h8B
  };

  // shifted symbol, or numpad navigation code
  localparam logic [8*(MAP_LAST+1)-1:0] SHIFT_KEYS = {
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h8C,
    8'h8E, 8'h92, 8'h00, 8'h90, 8'h00, 8'h91, 8'h00, 8'h8D,
    8'h8F, 8'h93, 8'h94, 8'h95, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00
  };

  // predicted keyboard state
  logic       caps_on, num_on, shift_l, shift_r, ctrl_held, alt_held;
  logic [2:0] esc_run;
  logic [2:0] exit_count;

  key_event_t expected_events[$];
  int         mismatches = 0;
  int         queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  // key code of a non-modifier scan byte under the current locks and shift
  function automatic logic [7:0] map_key(input logic [7:0] sc);
    logic       shifted;
    logic [7:0] lo, hi;
    int         pos;
    shifted = shift_l | shift_r;
    if (sc > SC_LAST) return 8'h00;
    pos = (MAP_LAST - int'(sc)) * 8;
    lo  = PLAIN_KEYS[pos +: 8];
    hi  = SHIFT_KEYS[pos +: 8];
    if (sc >= SC_PAD_FIRST && sc <= SC_PAD_LAST && sc != SC_PAD_MINUS && sc != SC_PAD_PLUS)
      return num_on ? lo : hi;
    if (lo >= KC_LOW_A && lo <= KC_LOW_Z) return (caps_on != shifted) ? hi : lo;
    if (hi != 8'h00 && shifted) return hi;
    return lo;
  endfunction

  // advance the keyboard state by one scan byte and return the key event
  function automatic key_event_t decode_scan(input logic [7:0] sc);
    key_event_t ev;
    logic [7:0] digit;
    ev.key  = 8'h00;
    ev.cmd  = HK_NONE;
    ev.term = 4'd0;
    case (sc)
      SC_CTRL_MAKE:   ctrl_held = 1'b1;
      SC_CTRL_BREAK:  ctrl_held = 1'b0;
      SC_LSHIFT_MAKE: shift_l = 1'b1;
      SC_LSHIFT_BRK:  shift_l = 1'b0;
      SC_RSHIFT_MAKE: shift_r = 1'b1;
      SC_RSHIFT_BRK:  shift_r = 1'b0;
      SC_ALT_MAKE:    alt_held = 1'b1;
      SC_ALT_BREAK:   alt_held = 1'b0;
      SC_CAPS:        caps_on = ~caps_on;
      SC_NUM:         num_on = ~num_on;
      default:        ev.key = map_key(sc);
    endcase

    // esc run, kept across esc releases
    if (ev.key == KC_ESC) begin
      if (esc_run != ESC_CNT_MAX) esc_run = esc_run + 3'd1;
      if (esc_run == exit_count) begin
        ev.cmd  = HK_EXIT;
        esc_run = 3'd0;
      end
    end else if (sc != SC_ESC_BREAK) begin
      esc_run = 3'd0;
    end

    // hotkeys swallow the key
    if (ev.cmd == HK_NONE) begin
      if (ctrl_held && ev.key == KC_MINUS) begin
        ev.cmd = HK_LOG_DOWN;
        ev.key = 8'h00;
      end else if (ctrl_held && ev.key == KC_EQUALS) begin
        ev.cmd = HK_LOG_UP;
        ev.key = 8'h00;
      end else if (alt_held && ev.key >= KC_ZERO && ev.key <= KC_NINE) begin
        digit   = ev.key - KC_ZERO;
        ev.cmd  = HK_SEL_TERM;
        ev.term = digit[3:0];
        ev.key  = 8'h00;
      end else if (ctrl_held && ev.key == KC_N) begin
        ev.cmd = HK_NEW_PROC;
        ev.key = 8'h00;
      end else if (ctrl_held && ev.key == KC_Q) begin
        ev.cmd = HK_KILL_PROC;
        ev.key = 8'h00;
      end
    end
    return ev;
  endfunction

  // predict on accepted scan bytes, compare on accepted key events
  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      caps_on    <= 1'b0;
      num_on     <= 1'b0;
      shift_l    <= 1'b0;
      shift_r    <= 1'b0;
      ctrl_held  <= 1'b0;
      alt_held   <= 1'b0;
      esc_run    <= 3'd0;
      exit_count <= ESC_EXIT_RESET;
      expected_events.delete();
    end else begin
      if (cfg_wr_en) exit_count = cfg_wr_data;
      if (in_valid && !in_stall) expected_events.push_back(decode_scan(in_scan_byte));
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("key event with none expected: key_code %0h command %0d",
                 out_key_code, out_hotkey_command);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (out_key_code !== want.key) begin
            $error("key_code: expected %0h, actual %0h", want.key, out_key_code);
            mismatches++;
          end
          if (out_hotkey_command !== want.cmd) begin
            $error("hotkey_command: expected %0d, actual %0d", want.cmd, out_hotkey_command);
            mismatches++;
          end
          if (out_terminal_index !== want.term) begin
            $error("terminal_index: expected %0d, actual %0d", want.term, out_terminal_index);
            mismatches++;
          end
        end
      end
    end
    queued = expected_events.size();
  end

endmodule

>>> verif/tb_scan_code_to_ascii_decoder.sv
`timescale 1ns / 100ps
// tb_scan_code_to_ascii_decoder: drives scan bytes, esc exit counts and output stalls
// into the decoder; scan_decode_checker predicts and compares, this top gives the verdict
// depends on sc2a_pkg, scan_code_to_ascii_decoder and scan_decode_checker
module tb_scan_code_to_ascii_decoder;
  import sc2a_pkg::*;

  localparam int         LIMIT_CYCLES = 200000;
  localparam logic [7:0] RELEASE_BIT  = 8'h80;
  localparam logic [7:0] SC_ESC_MAKE  = 8'h01;
  localparam logic [7:0] SC_ONE_KEY   = 8'h02;
  localparam logic [7:0] SC_TWO_KEY   = 8'h03;
  localparam logic [7:0] SC_NINE_KEY  = 8'h0A;
  localparam logic [7:0] SC_ZERO_KEY  = 8'h0B;
  localparam logic [7:0] SC_MINUS_KEY = 8'h0C;
  localparam logic [7:0] SC_EQUAL_KEY = 8'h0D;
  localparam logic [7:0] SC_Q_KEY     = 8'h10;
  localparam logic [7:0] SC_A_KEY     = 8'h1E;
  localparam logic [7:0] SC_N_KEY     = 8'h31;
  localparam logic [7:0] SC_PAD_UP    = 8'h48;
  localparam logic [7:0] SC_PAD_FIVE  = 8'h4C;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = 3'd0;
  logic       in_valid = 1'b0;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_key_code;
  logic [2:0] out_hotkey_command;
  logic [3:0] out_terminal_index;
  int         fail_count;
  int         pending;
  bit         quiet = 1'b0;
  int         sent_items = 0;
  int         cycle_count = 0;

  scan_code_to_ascii_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_scan_byte      (in_scan_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_code      (out_key_code),
    .out_hotkey_command(out_hotkey_command),
    .out_terminal_index(out_terminal_index)
  );

  scan_decode_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_scan_byte      (in_scan_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_code      (out_key_code),
    .out_hotkey_command(out_hotkey_command),
    .out_terminal_index(out_terminal_index),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random outside quiet stretches
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("scan_code_to_ascii_decoder: mismatch");
      $finish;
    end
  end

  // one item, with a random gap in front of it
  task automatic send_scan(input logic [7:0] sc);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_byte <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // stop sending, let every key event come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_exit_count(input logic [2:0] count);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one keystroke group: modifiers, locks, esc runs, hotkey keys, plain keys, noise
  task automatic random_stroke();
    int         pick;
    int         run;
    logic [7:0] sc;
    pick = $urandom_range(99);
    if (pick < 25) begin
      case ($urandom_range(7))
        0: sc = SC_CTRL_MAKE;
        1: sc = SC_CTRL_BREAK;
        2: sc = SC_LSHIFT_MAKE;
        3: sc = SC_LSHIFT_BRK;
        4: sc = SC_RSHIFT_MAKE;
        5: sc = SC_RSHIFT_BRK;
        6: sc = SC_ALT_MAKE;
        default: sc = SC_ALT_BREAK;
      endcase
      send_scan(sc);
    end else if (pick < 32) begin
      case ($urandom_range(3))
        0: sc = SC_CAPS;
        1: sc = SC_NUM;
        2: sc = SC_CAPS | RELEASE_BIT;
        default: sc = SC_NUM | RELEASE_BIT;
      endcase
      send_scan(sc);
    end else if (pick < 44) begin
      run = $urandom_range(1, 8);
      repeat (run) begin
        send_scan(SC_ESC_MAKE);
        if ($urandom_range(2) == 0) send_scan(SC_ESC_BREAK);
      end
    end else if (pick < 58) begin
      case ($urandom_range(5))
        0: sc = SC_MINUS_KEY;
        1: sc = SC_EQUAL_KEY;
        2: sc = SC_N_KEY;
        3: sc = SC_Q_KEY;
        4: sc = 8'($urandom_range(SC_ONE_KEY, SC_ZERO_KEY));
        default: sc = 8'($urandom_range(SC_PAD_FIRST, SC_PAD_LAST));
      endcase
      send_scan(sc);
      if ($urandom_range(1)) send_scan(sc | RELEASE_BIT);
    end else if (pick < 90) begin
      sc = 8'($urandom_range(0, SC_LAST));
      send_scan(sc);
      if ($urandom_range(1)) send_scan(sc | RELEASE_BIT);
    end else begin
      send_scan(8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int count);
    int start;
    start = sent_items;
    while (sent_items - start < count) random_stroke();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, case and shift, locks, numpad, hotkeys, esc exit at 3
    send_scan(8'h00);
    send_scan(8'hFF);
    send_scan(SC_A_KEY);
    send_scan(SC_CAPS);
    send_scan(SC_A_KEY);
    send_scan(SC_LSHIFT_MAKE);
    send_scan(SC_A_KEY);
    send_scan(SC_TWO_KEY);
    send_scan(SC_LSHIFT_BRK);
    send_scan(SC_RSHIFT_MAKE);
    send_scan(SC_MINUS_KEY);
    send_scan(SC_RSHIFT_BRK);
    send_scan(SC_CAPS);
    send_scan(SC_CAPS | RELEASE_BIT);
    send_scan(SC_PAD_FIVE);
    send_scan(SC_PAD_UP);
    send_scan(SC_NUM);
    send_scan(SC_PAD_UP);
    send_scan(SC_CTRL_MAKE);
    send_scan(SC_PAD_MINUS);
    send_scan(SC_EQUAL_KEY);
    send_scan(SC_N_KEY);
    send_scan(SC_Q_KEY);
    send_scan(SC_CTRL_BREAK);
    send_scan(SC_ALT_MAKE);
    send_scan(SC_ZERO_KEY);
    send_scan(SC_NINE_KEY);
    send_scan(SC_ALT_BREAK);
    send_scan(SC_ESC_MAKE);
    send_scan(SC_ESC_BREAK);
    send_scan(SC_ESC_MAKE);
    send_scan(SC_ESC_MAKE);
    send_scan(SC_LAST);
    send_scan(SC_LAST + 8'h01);

    // exit on the first esc
    set_exit_count(3'd1);
    send_scan(SC_ESC_MAKE);
    random_phase(400);

    // highest count, no idling on either side
    set_exit_count(3'd7);
    quiet = 1'b1;
    random_phase(400);
    quiet = 1'b0;

    // exit count zero: the run saturates at seven and never exits
    set_exit_count(3'd0);
    repeat (9) send_scan(SC_ESC_MAKE);
    random_phase(330);

    set_exit_count(3'($urandom_range(2, 6)));
    random_phase(380);

    set_exit_count(3'd2);
    random_phase(380);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("scan_code_to_ascii_decoder: match");
    end else begin
      $display("scan_code_to_ascii_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sc2a_pkg.sv
sv/scan_code_to_ascii_decoder.sv
verif/scan_decode_checker.sv
verif/tb_scan_code_to_ascii_decoder.sv
